@@ sv/hbdmc_pkg.sv @@
`default_nettype none

package hbdmc_pkg;

  // Port table size and field widths
  localparam int PORT_COUNT = 6;
  localparam int PORT_W     = 3;
  localparam int DUTY_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int CMP_W      = 12;

  localparam logic [LIMIT_W-1:0] DUTY_LIMIT_RESET = 15'd10000;

  // Divide by ten: (mag * 52429) >> 19, exact for all 15-bit magnitudes
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  // Command opcodes
  localparam logic [2:0] OP_SET_DUTY = 3'd0;
  localparam logic [2:0] OP_COAST    = 3'd1;
  localparam logic [2:0] OP_BRAKE    = 3'd2;
  localparam logic [2:0] OP_PIN      = 3'd3;
  localparam logic [2:0] OP_UNPIN    = 3'd4;
  localparam logic [2:0] OP_STATUS   = 3'd5;

  // Port modes
  localparam logic [1:0] MODE_COAST = 2'd0;
  localparam logic [1:0] MODE_BRAKE = 2'd1;
  localparam logic [1:0] MODE_PWM   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_BUSY  = 2'd3;

  // Bridge pin drive codes
  localparam logic [1:0] DRV_LOW  = 2'd0;
  localparam logic [1:0] DRV_HIGH = 2'd1;
  localparam logic [1:0] DRV_PWM  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic commit;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // One result word
  typedef struct packed {
    logic              via_brake;
    logic              compare_written;
    logic              compare_on_pin2;
    logic [CMP_W-1:0]  compare_value;
    logic [1:0]        pin2_drive;
    logic [1:0]        pin1_drive;
    logic              is_pinned;
    logic [DUTY_W-1:0] duty_now;
    logic [1:0]        port_mode;
    logic [1:0]        status;
  } result_t;

endpackage

`default_nettype wire

@@ sv/hbdmc_ctrl.sv @@
`default_nettype none

module hbdmc_ctrl
  import hbdmc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Capture a command word in idle, execute it once the output register is free
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_commit_in_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> state == S_EXEC)
    else $error("commit outside execute state");

  a_load_to_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_EXEC)
    else $error("accepted word not executed next");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> !cmd.load)
    else $error("word captured while executing");

endmodule

`default_nettype wire

@@ sv/hbdmc_dpath.sv @@
`default_nettype none

module hbdmc_dpath
  import hbdmc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctl_cmd_t          cmd,
  output dp_stat_t               stat,
  input  wire logic [2:0]        opcode,
  input  wire logic [PORT_W-1:0] port,
  input  wire logic [DUTY_W-1:0] duty_request,
  input  wire logic [1:0]        supply_sign,
  input  wire logic              cfg_wr_en,
  input  wire logic [LIMIT_W-1:0] cfg_wr_data,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output result_t                out_word
);

  logic [2:0]        in_op;
  logic [PORT_W-1:0] in_port;
  logic [DUTY_W-1:0] in_duty;
  logic [1:0]        in_sign;
  logic [LIMIT_W-1:0] duty_limit;

  logic [PORT_COUNT-1:0][1:0]        mode_store;
  logic [PORT_COUNT-1:0][DUTY_W-1:0] duty_store;
  logic [PORT_COUNT-1:0]             pin_store;

  logic              out_full;

  logic [1:0]        cur_mode;
  logic [DUTY_W-1:0] cur_duty;
  logic              cur_pin;
  logic              bad_port;
  logic [DUTY_W:0]   req_mag;
  logic              over_range;
  logic [DUTY_W-1:0] limit_ext;
  logic [DUTY_W-1:0] tgt;
  logic [DUTY_W-1:0] tgt_abs;
  logic [LIMIT_W+15:0] div_prod;
  logic [CMP_W-1:0]  div_q;
  logic              do_drive;
  logic [1:0]        st;
  logic [1:0]        new_mode;
  logic [DUTY_W-1:0] new_duty;
  logic              new_pin;
  logic              cmp_wr;
  logic              brake_flag;
  logic [1:0]        p1;
  logic [1:0]        p2;
  result_t           res;

  // Capture the command word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_op   <= opcode;
      in_port <= port;
      in_duty <= duty_request;
      in_sign <= supply_sign;
    end
  end

  // Duty limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_limit <= DUTY_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      duty_limit <= cfg_wr_data;
    end
  end

  // Read the addressed port's entry
  always_comb begin
    cur_mode = MODE_COAST;
    cur_duty = '0;
    cur_pin  = 1'b0;
    for (int i = 0; i < PORT_COUNT; i++) begin
      if ({1'b0, in_port} == (PORT_W+1)'(i)) begin
        cur_mode = mode_store[i];
        cur_duty = duty_store[i];
        cur_pin  = pin_store[i];
      end
    end
  end

  assign bad_port  = {1'b0, in_port} >= (PORT_W+1)'(PORT_COUNT);
  assign req_mag   = in_duty[DUTY_W-1] ? ((DUTY_W+1)'(0) - {1'b1, in_duty})
                                       : {1'b0, in_duty};
  assign over_range = req_mag > (DUTY_W+1)'(duty_limit);
  assign limit_ext = DUTY_W'(duty_limit);

  // Drive target: requested duty, or the rail value for pin supply
  always_comb begin
    if (in_op == OP_PIN) begin
      tgt = in_sign[1] ? (DUTY_W'(0) - limit_ext) : limit_ext;
    end else begin
      tgt = in_duty;
    end
  end

  // Compare ticks: magnitude over ten by reciprocal multiply
  assign tgt_abs  = tgt[DUTY_W-1] ? (DUTY_W'(0) - tgt) : tgt;
  assign div_prod = tgt_abs[LIMIT_W-1:0] * DIV10_MUL;
  assign div_q    = div_prod[DIV10_SHIFT +: CMP_W];

  // Decode the command against the port's current state
  always_comb begin
    st         = ST_OK;
    new_mode   = cur_mode;
    new_duty   = cur_duty;
    new_pin    = cur_pin;
    do_drive   = 1'b0;
    cmp_wr     = 1'b0;
    brake_flag = 1'b0;
    case (in_op)
      OP_SET_DUTY: begin
        if (over_range) begin
          st = ST_RANGE;
        end else if (cur_pin) begin
          st = ST_BUSY;
        end else begin
          do_drive = 1'b1;
        end
      end
      OP_COAST: begin
        if (!cur_pin) begin
          new_mode = MODE_COAST;
          new_duty = '0;
        end
      end
      OP_BRAKE: begin
        if (cur_pin) begin
          st = ST_BUSY;
        end else begin
          new_mode = MODE_BRAKE;
          new_duty = '0;
        end
      end
      OP_PIN: begin
        if (in_sign == 2'b00) begin
          st = ST_INVAL;
        end else begin
          do_drive = 1'b1;
          new_pin  = 1'b1;
        end
      end
      OP_UNPIN: begin
        new_pin  = 1'b0;
        new_mode = MODE_COAST;
        new_duty = '0;
      end
      OP_STATUS: begin
      end
      default: begin
        st = ST_INVAL;
      end
    endcase

    // Zero brakes; same sign in pwm rewrites compare; else brake then drive
    if (do_drive) begin
      if (tgt == '0) begin
        new_mode = MODE_BRAKE;
        new_duty = '0;
      end else if (cur_mode == MODE_PWM && cur_duty != '0 &&
                   cur_duty[DUTY_W-1] == tgt[DUTY_W-1]) begin
        cmp_wr   = 1'b1;
        new_duty = tgt;
      end else begin
        brake_flag = 1'b1;
        cmp_wr     = 1'b1;
        new_mode   = MODE_PWM;
        new_duty   = tgt;
      end
    end
  end

  // Pin drive from the resulting mode and duty sign
  always_comb begin
    p1 = DRV_LOW;
    p2 = DRV_LOW;
    case (new_mode)
      MODE_BRAKE: begin
        p1 = DRV_HIGH;
        p2 = DRV_HIGH;
      end
      MODE_PWM: begin
        if (!new_duty[DUTY_W-1]) begin
          p1 = DRV_PWM;
          p2 = DRV_HIGH;
        end else begin
          p1 = DRV_HIGH;
          p2 = DRV_PWM;
        end
      end
      default: begin
      end
    endcase
  end

  // Assemble the result; a bad port reports nothing but the error
  always_comb begin
    res = '0;
    if (bad_port) begin
      res.status = ST_INVAL;
    end else begin
      res.status          = st;
      res.port_mode       = new_mode;
      res.duty_now        = new_duty;
      res.is_pinned       = new_pin;
      res.pin1_drive      = p1;
      res.pin2_drive      = p2;
      res.compare_value   = cmp_wr ? div_q : '0;
      res.compare_on_pin2 = cmp_wr & tgt[DUTY_W-1];
      res.compare_written = cmp_wr;
      res.via_brake       = brake_flag;
    end
  end

  // Write back the addressed entry
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_store <= '0;
      duty_store <= '0;
      pin_store  <= '0;
    end else if (cmd.commit && !bad_port) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        if ({1'b0, in_port} == (PORT_W+1)'(i)) begin
          mode_store[i] <= new_mode;
          duty_store[i] <= new_duty;
          pin_store[i]  <= new_pin;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_word <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.commit) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  assign out_valid     = out_full;
  assign stat.out_free = !out_full || out_ready;

  a_commit_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_full)
    else $error("commit did not fill output register");

  a_store_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> ($stable(mode_store) && $stable(duty_store) && $stable(pin_store)))
    else $error("port table changed without commit");

  a_cmp_pwm: assert property (@(posedge clk) disable iff (rst)
    res.compare_written |-> res.port_mode == MODE_PWM)
    else $error("compare written outside pwm mode");

endmodule

`default_nettype wire

@@ sv/hbridge_drive_mode_control.sv @@
// H-bridge drive mode controller, one command word per port operation.
// Input stream (s_axis): a command names a port and one of set duty, coast,
// brake, pin supply, unpin or status. Output stream (m_axis): one result
// word per command with status, the port's mode, duty, pin flag, pin drive
// codes and any compare value written.
// The duty limit register is written through cfg_wr_en / cfg_wr_data; the
// user must do so only while no command is in flight, which the block does
// not enforce. The compare value is the duty magnitude over ten. Each word
// is captured on acceptance and executed once the output register is free,
// which registers its result; no new word is accepted while one executes.
// The output register holds a result while the next command is captured;
// if m_axis_tready stays low, execution of that command waits and
// s_axis_tready stays low until the held result is taken.
// Reset: every port coasts with zero duty and unpinned, duty limit 10000,
// no result pending.
`default_nettype none

module hbridge_drive_mode_control
  import hbdmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // opcode[2:0], port[5:3], duty_request[21:6], supply_sign[23:22]
  input  wire logic [23:0] s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // status[1:0], port_mode[3:2], duty_now[19:4], is_pinned[20],
  // pin1_drive[22:21], pin2_drive[24:23], compare_value[36:25],
  // compare_on_pin2[37], compare_written[38], via_brake[39]
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        cfg_wr_en,
  input  wire logic [14:0] cfg_wr_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;
  result_t  out_word;

  hbdmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hbdmc_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (s_axis_tdata[2:0]),
    .port         (s_axis_tdata[5:3]),
    .duty_request (s_axis_tdata[21:6]),
    .supply_sign  (s_axis_tdata[23:22]),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_word     (out_word)
  );

  // Pack the result word, status field lowest
  assign m_axis_tdata = out_word;

endmodule

`default_nettype wire

@@ test/hbridge_drive_mode_control_test.sv @@
`default_nettype none

module hbridge_drive_mode_control_test;
  import hbdmc_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 250;
  localparam int HOLD_CYCLES  = 300;
  localparam int REPORT_LIMIT = 200;

  // Opcodes the block must reject
  localparam logic [2:0] OP_BAD_LO = 3'd6;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

  // Command word, last field in the low bits
  typedef struct packed {
    logic signed [1:0]  supply_sign;
    logic signed [15:0] duty_request;
    logic [2:0]         port;
    logic [2:0]         opcode;
  } cmd_t;

  typedef struct {
    cmd_t    cmd;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [14:0] cfg_wr_data = '0;

  // Shadow of the port table and the limit register
  logic [1:0] port_mode_q [PORT_COUNT];
  int         port_duty_q [PORT_COUNT];
  bit         port_pinned_q [PORT_COUNT];
  int         duty_limit_q;

  result_t    pending_results[$];
  dir_row_t   dir_rows[$];

  int mismatches = 0;
  int commands_sent = 0;
  int results_seen = 0;
  int status_seen [4];
  int burst_left = 0;
  int gap_max = 0;
  int focus_port = 0;
  int stall_pct = 0;
  int hold_req = 0;

  hbridge_drive_mode_control i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // Zero duty brakes; nonzero duty: same sign in pwm rewrites compare, else pass through brake
  function automatic void drive_port(input int p, input int d, inout result_t r);
    int mag;
    if (d == 0) begin
      port_mode_q[p] = MODE_BRAKE;
      port_duty_q[p] = 0;
      return;
    end
    if (!(port_mode_q[p] == MODE_PWM &&
          ((port_duty_q[p] > 0 && d > 0) || (port_duty_q[p] < 0 && d < 0)))) begin
      r.via_brake = 1'b1;
      port_mode_q[p] = MODE_PWM;
    end
    mag = (d < 0) ? -d : d;
    r.compare_value   = CMP_W'(mag / 10);
    r.compare_on_pin2 = (d < 0);
    r.compare_written = 1'b1;
    port_duty_q[p] = d;
  endfunction

  // Apply one command to the shadow table and build its result word
  function automatic result_t bridge_result(input cmd_t c);
    result_t r;
    int p, d, s, mag;
    r = '0;
    p = int'(c.port);
    if (p >= PORT_COUNT) begin
      r.status = ST_INVAL;
      return r;
    end
    d = $signed(c.duty_request);
    s = $signed(c.supply_sign);
    r.status = ST_OK;
    case (c.opcode)
      OP_SET_DUTY: begin
        mag = (d < 0) ? -d : d;
        if (mag > duty_limit_q) r.status = ST_RANGE;
        else if (port_pinned_q[p]) r.status = ST_BUSY;
        else drive_port(p, d, r);
      end
      OP_COAST: begin
        if (!port_pinned_q[p]) begin
          port_mode_q[p] = MODE_COAST;
          port_duty_q[p] = 0;
        end
      end
      OP_BRAKE: begin
        if (port_pinned_q[p]) begin
          r.status = ST_BUSY;
        end else begin
          port_mode_q[p] = MODE_BRAKE;
          port_duty_q[p] = 0;
        end
      end
      OP_PIN: begin
        if (s == 0) begin
          r.status = ST_INVAL;
        end else begin
          drive_port(p, (s > 0) ? duty_limit_q : -duty_limit_q, r);
          port_pinned_q[p] = 1'b1;
        end
      end
      OP_UNPIN: begin
        port_pinned_q[p] = 1'b0;
        port_mode_q[p] = MODE_COAST;
        port_duty_q[p] = 0;
      end
      OP_STATUS: ;
      default: r.status = ST_INVAL;
    endcase
    r.port_mode  = port_mode_q[p];
    r.duty_now   = DUTY_W'(port_duty_q[p]);
    r.is_pinned  = port_pinned_q[p];
    r.pin1_drive = DRV_LOW;
    r.pin2_drive = DRV_LOW;
    if (port_mode_q[p] == MODE_BRAKE) begin
      r.pin1_drive = DRV_HIGH;
      r.pin2_drive = DRV_HIGH;
    end else if (port_mode_q[p] == MODE_PWM) begin
      r.pin1_drive = (port_duty_q[p] >= 0) ? DRV_PWM : DRV_HIGH;
      r.pin2_drive = (port_duty_q[p] >= 0) ? DRV_HIGH : DRV_PWM;
    end
    return r;
  endfunction

  function automatic cmd_t mk_cmd(input logic [2:0] op, input int port, input int duty,
                                  input int sign);
    cmd_t c;
    c.opcode       = op;
    c.port         = 3'(port);
    c.duty_request = 16'(duty);
    c.supply_sign  = 2'(sign);
    return c;
  endfunction

  function automatic result_t mk_res(input logic [1:0] st, input logic [1:0] mode,
                                     input int duty, input bit pinned,
                                     input logic [1:0] p1, input logic [1:0] p2,
                                     input int cmp, input bit on2, input bit wr,
                                     input bit vb);
    result_t r;
    r.status          = st;
    r.port_mode       = mode;
    r.duty_now        = DUTY_W'(duty);
    r.is_pinned       = pinned;
    r.pin1_drive      = p1;
    r.pin2_drive      = p2;
    r.compare_value   = CMP_W'(cmp);
    r.compare_on_pin2 = on2;
    r.compare_written = wr;
    r.via_brake       = vb;
    return r;
  endfunction

  // Mostly runs on one port so pwm updates and pin sequences build up
  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick, lim, mag;
    lim = duty_limit_q;
    if ($urandom_range(0, 9) < 3) focus_port = $urandom_range(0, PORT_COUNT - 1);
    c.port = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(PORT_COUNT, 7))
                                          : 3'(focus_port);
    c.supply_sign  = 2'($urandom);
    c.duty_request = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      c.opcode = OP_SET_DUTY;
      case ($urandom_range(0, 9))
        0: c.duty_request = '0;
        1: c.duty_request = 16'($urandom_range(0, 1) ? -lim : lim);
        2: c.duty_request = 16'($urandom_range(0, 1) ? -(lim + 1) : lim + 1);
        3: ;
        4: c.duty_request = 16'h8000;
        default: begin
          mag = $urandom_range(0, lim);
          c.duty_request = 16'($urandom_range(0, 1) ? -mag : mag);
        end
      endcase
    end else if (pick < 55) c.opcode = OP_COAST;
    else if (pick < 63) c.opcode = OP_BRAKE;
    else if (pick < 72) c.opcode = OP_PIN;
    else if (pick < 80) c.opcode = OP_UNPIN;
    else if (pick < 95) c.opcode = OP_STATUS;
    else c.opcode = $urandom_range(0, 1) ? OP_BAD_LO : OP_BAD_HI;
    return c;
  endfunction

  // Offer one word in bursts with random gaps when gap_max is nonzero; record its result on acceptance
  task automatic send_cmd(input cmd_t c, input bit typed, input result_t typed_res);
    result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gap_max != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
    s_axis_tdata  <= c;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    r = bridge_result(c);
    pending_results.push_back(typed ? typed_res : r);
    burst_left--;
    commands_sent++;
  endtask

  // Hold the input until every expected word is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_limit(input int v);
    drain();
    cfg_wr_data <= 15'(v);
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    duty_limit_q = v;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Receiver: random ready runs, plus a long hold on request
  always @(posedge clk) begin
    int hold_left, hold_seen, run_left;
    bit run_ready;
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_ready = ($urandom_range(0, 99) >= stall_pct);
        run_left = $urandom_range(1, 6);
      end
      run_left--;
      m_axis_tready <= run_ready;
    end
  end

  // Compare each taken word with the oldest expectation
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none, got %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        status_seen[got.status]++;
        check_field("status", want.status, got.status);
        check_field("port_mode", want.port_mode, got.port_mode);
        check_field("duty_now", $signed(want.duty_now), $signed(got.duty_now));
        check_field("is_pinned", want.is_pinned, got.is_pinned);
        check_field("pin1_drive", want.pin1_drive, got.pin1_drive);
        check_field("pin2_drive", want.pin2_drive, got.pin2_drive);
        check_field("compare_value", want.compare_value, got.compare_value);
        check_field("compare_on_pin2", want.compare_on_pin2, got.compare_on_pin2);
        check_field("compare_written", want.compare_written, got.compare_written);
        check_field("via_brake", want.via_brake, got.via_brake);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    int cycle_count;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hbridge_drive_mode_control_test: done, errors");
      $finish;
    end
  end

  initial begin
    int phase_limit [PHASES];
    int phase_stall [PHASES];
    int phase_gap [PHASES];
    result_t zero_inval, zero_range;
    phase_limit = '{10000, 32767, 0, 1, 0, 10000};
    phase_stall = '{0, 30, 60, 10, 45, 20};
    phase_gap   = '{0, 4, 8, 2, 10, 0};
    phase_limit[4] = $urandom_range(2, 32766);
    for (int i = 0; i < PORT_COUNT; i++) begin
      port_mode_q[i] = MODE_COAST;
      port_duty_q[i] = 0;
      port_pinned_q[i] = 1'b0;
    end
    duty_limit_q = int'(DUTY_LIMIT_RESET);
    zero_inval = mk_res(ST_INVAL, MODE_COAST, 0, 0, DRV_LOW, DRV_LOW, 0, 0, 0, 0);
    zero_range = mk_res(ST_RANGE, MODE_COAST, 0, 0, DRV_LOW, DRV_LOW, 0, 0, 0, 0);

    // Directed commands, reset duty limit
    dir_rows.push_back('{mk_cmd(OP_STATUS, 0, 0, 0), 1'b1,
                         mk_res(ST_OK, MODE_COAST, 0, 0, DRV_LOW, DRV_LOW, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_cmd(OP_SET_DUTY, 0, 0, 0), 1'b1,
                         mk_res(ST_OK, MODE_BRAKE, 0, 0, DRV_HIGH, DRV_HIGH, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_cmd(OP_SET_DUTY, 0, 10000, 0), 1'b1,
                         mk_res(ST_OK, MODE_PWM, 10000, 0, DRV_PWM, DRV_HIGH,
                                1000, 0, 1, 1)});
    dir_rows.push_back('{mk_cmd(OP_SET_DUTY, 0, 5005, 0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_SET_DUTY, 0, -10000, 0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_SET_DUTY, 0, -10001, 0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_SET_DUTY, 1, -32768, 0), 1'b1, zero_range});
    dir_rows.push_back('{mk_cmd(OP_SET_DUTY, 1, 32767, 0), 1'b1, zero_range});
    dir_rows.push_back('{mk_cmd(OP_PIN, 2, 0, 1), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_SET_DUTY, 2, 100, 0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_BRAKE, 2, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_COAST, 2, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_PIN, 2, 0, -2), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_PIN, 3, 0, 0), 1'b1, zero_inval});
    dir_rows.push_back('{mk_cmd(OP_UNPIN, 2, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_STATUS, 6, 0, 0), 1'b1, '0 | zero_inval});
    dir_rows.push_back('{mk_cmd(OP_SET_DUTY, 7, 5, 1), 1'b1, zero_inval});
    dir_rows.push_back('{mk_cmd(OP_BAD_LO, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_BAD_HI, 5, -1, -1), 1'b1, zero_inval});
    dir_rows.push_back('{mk_cmd(OP_COAST, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_BRAKE, 4, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_STATUS, 4, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_SET_DUTY, 5, -1, 0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_SET_DUTY, 5, -9, 0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_SET_DUTY, 5, 32767, 0), 1'b0, '0});

    // Hold reset, then release
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    gap_max = 3;
    stall_pct <= 25;
    foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

    // Random phases, one duty limit setting each
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) write_limit(phase_limit[ph]);
      gap_max = phase_gap[ph];
      stall_pct <= phase_stall[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 20) hold_req <= hold_req + 1;
        if (ph == 3 && n == PHASE_ITEMS / 2) drain();
        send_cmd(random_cmd(), 1'b0, '0);
      end
    end

    drain();
    $display("Sent %0d commands over %0d duty limit settings (0 and 32767 included).",
             commands_sent, PHASES);
    $display("Checked %0d result words: ok %0d, invalid %0d, range %0d, busy %0d.",
             results_seen, status_seen[ST_OK], status_seen[ST_INVAL],
             status_seen[ST_RANGE], status_seen[ST_BUSY]);
    if (mismatches == 0) begin
      $display("hbridge_drive_mode_control_test: done, clean");
    end else begin
      $display("hbridge_drive_mode_control_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ hbridge_drive_mode_control.f @@
sv/hbdmc_pkg.sv
sv/hbdmc_ctrl.sv
sv/hbdmc_dpath.sv
sv/hbridge_drive_mode_control.sv
test/hbridge_drive_mode_control_test.sv
